/* rtl/video_register_port_core_macros.svh */
// Assertion helpers used by the register port RTL.
`ifndef VIDEO_REGISTER_PORT_CORE_MACROS_SVH
`define VIDEO_REGISTER_PORT_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define VRP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define VRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/vrp_pkg.sv */
`timescale 1ns / 1ps

package vrp_pkg;

   localparam int VIDEO_DEPTH  = 16384;
   localparam int SPRITE_DEPTH = 256;
   localparam int VADDR_W      = $clog2(VIDEO_DEPTH);
   localparam int SADDR_W      = $clog2(SPRITE_DEPTH);
   localparam int PAL_DEPTH    = 32;
   localparam int PAL_IDX_W    = $clog2(PAL_DEPTH);

   localparam logic [VADDR_W-1:0] PAL_BASE        = VADDR_W'(16'h3F00);
   localparam logic [VADDR_W-1:0] BUF_MIRROR_MASK = VADDR_W'(16'h2FFF);
   localparam logic [7:0]         SPR_ATTR_MASK   = 8'hE3;
   localparam logic [1:0]         SPR_ATTR_SLOT   = 2'd2;
   localparam logic [VADDR_W-1:0] STRIDE_ROW      = VADDR_W'(32);
   localparam logic [VADDR_W-1:0] STRIDE_ONE      = VADDR_W'(1);

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_RESET  = 2'd2,
      MODE_STATUS = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_CONTROL     = 3'd0,
      REG_MASK        = 3'd1,
      REG_STATUS      = 3'd2,
      REG_SPRITE_ADDR = 3'd3,
      REG_SPRITE_DATA = 3'd4,
      REG_SCROLL      = 3'd5,
      REG_ADDRESS     = 3'd6,
      REG_DATA        = 3'd7
   } reg_type;

   // Work left for the second stage, which owns the bus latch and read buffer.
   typedef enum logic [2:0] {
      OP_LATCH,
      OP_STATUS,
      OP_SPRITE,
      OP_DATA,
      OP_WRITE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       pal;
   } issue_type;

   typedef struct packed {
      logic               we;
      logic [VADDR_W-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               re;
      logic [VADDR_W-1:0] rd_addr;
   } vid_cmd_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
   } vid_rsp_type;

   typedef struct packed {
      logic               we;
      logic [SADDR_W-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               re;
      logic [SADDR_W-1:0] rd_addr;
   } spr_cmd_type;

   typedef struct packed {
      logic               nmi;
      logic [VADDR_W-1:0] vram;
      logic [2:0]         fine_x;
   } view_type;

   function automatic logic [7:0] palette_preset(input logic [PAL_IDX_W-1:0] idx);
      logic [7:0] v;
      case (idx)
         5'd0:  v = 8'h09;  5'd1:  v = 8'h01;  5'd2:  v = 8'h00;  5'd3:  v = 8'h01;
         5'd4:  v = 8'h00;  5'd5:  v = 8'h02;  5'd6:  v = 8'h02;  5'd7:  v = 8'h0D;
         5'd8:  v = 8'h08;  5'd9:  v = 8'h10;  5'd10: v = 8'h08;  5'd11: v = 8'h24;
         5'd12: v = 8'h00;  5'd13: v = 8'h00;  5'd14: v = 8'h04;  5'd15: v = 8'h2C;
         5'd16: v = 8'h09;  5'd17: v = 8'h01;  5'd18: v = 8'h34;  5'd19: v = 8'h03;
         5'd20: v = 8'h00;  5'd21: v = 8'h04;  5'd22: v = 8'h00;  5'd23: v = 8'h14;
         5'd24: v = 8'h08;  5'd25: v = 8'h3A;  5'd26: v = 8'h00;  5'd27: v = 8'h02;
         5'd28: v = 8'h00;  5'd29: v = 8'h20;  5'd30: v = 8'h2C;  5'd31: v = 8'h08;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

/* rtl/video_register_port_core.sv */
`timescale 1ns / 1ps

// CPU register port of a tile video chip. Each request is a bus read, a bus
// write, a soft reset or a status update from the renderer, and each gives
// exactly one response: read data (the open-bus latch when nothing is read),
// the NMI request, the 14-bit current video address and fine X scroll.
// Throughput is one request per clock while no response stalls. A request
// is accepted in the cycle where the address latches, control and status
// bits update and the sprite and video memories are written or read; the
// request then waits in the second stage while the memories register their
// read data, and the response is registered when that stage advances.
// A stalled response holds a full second stage; no new request is taken.
// Video memory is a flat 16K x 8 store with two read ports; the 32-entry
// palette window reads its preset until written. Sprite memory reads zero
// until written. Neither memory needs a clearing pass after reset.

`include "video_register_port_core_macros.svh"

module video_register_port_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_register_index,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_request,
   output logic [13:0] rsp_vram_address,
   output logic [2:0]  rsp_fine_x_scroll
);

   logic                 req_fire;
   logic                 p_advance;
   vrp_pkg::issue_type   issue;
   vrp_pkg::vid_cmd_type vid_cmd;
   vrp_pkg::vid_rsp_type vid_rsp;
   vrp_pkg::spr_cmd_type spr_cmd;
   vrp_pkg::view_type    view;
   logic [7:0]           spr_rd;

   // Second stage: what the accepted request still owes the bus side.
   logic                 p_valid_ff, p_valid_in;
   vrp_pkg::op_type      p_op_ff;
   logic [7:0]           p_data_ff;
   logic                 p_pal_ff;

   logic [7:0]           bus_latch_ff, bus_latch_in;
   logic [7:0]           read_buf_ff,  read_buf_in;
   logic [7:0]           rd;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff;
   logic                 rsp_nmi_ff;
   logic [13:0]          rsp_vram_ff;
   logic [2:0]           rsp_fine_x_ff;

   // Advance the second stage whenever the output register is free or draining.
   assign p_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !p_valid_ff || p_advance;
   assign req_fire  = req_valid && req_ready;

   vrp_regs u_regs (
      .clock              (clock),
      .reset              (reset),
      .req_fire           (req_fire),
      .req_mode           (req_mode),
      .req_register_index (req_register_index),
      .req_write_data     (req_write_data),
      .issue              (issue),
      .vid_cmd            (vid_cmd),
      .spr_cmd            (spr_cmd),
      .view               (view)
   );

   vrp_video_mem u_video_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (vid_cmd),
      .rsp   (vid_rsp)
   );

   vrp_sprite_mem u_sprite_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (spr_cmd),
      .rd_data (spr_rd)
   );

   // Resolve read data, then update the bus latch and the delayed read buffer.
   always_comb begin
      rd           = bus_latch_ff;
      read_buf_in  = read_buf_ff;
      case (p_op_ff)
         vrp_pkg::OP_STATUS: begin
            rd = {p_data_ff[7:5], bus_latch_ff[4:0]};
         end
         vrp_pkg::OP_SPRITE: begin
            rd = spr_rd;
         end
         vrp_pkg::OP_DATA: begin
            if (p_pal_ff) begin
               // Palette reads bypass the buffer; buffer takes the mirrored byte.
               rd          = vid_rsp.a;
               read_buf_in = vid_rsp.b;
            end else begin
               rd          = read_buf_ff;
               read_buf_in = vid_rsp.a;
            end
         end
         vrp_pkg::OP_WRITE: begin
            rd = p_data_ff;
         end
         vrp_pkg::OP_CLEAR: begin
            rd          = 8'h00;
            read_buf_in = 8'h00;
         end
         default: begin
            rd = bus_latch_ff;
         end
      endcase
      bus_latch_in = rd;
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      if (req_fire) begin
         p_valid_in = 1'b1;
      end else if (p_advance) begin
         p_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (p_valid_ff && p_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bus_latch_ff <= 8'h00;
         read_buf_ff  <= 8'h00;
      end else begin
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (p_valid_ff && p_advance) begin
            bus_latch_ff <= bus_latch_in;
            read_buf_ff  <= read_buf_in;
         end
      end
   end

   // Payload registers: load the stage on accept, the response on advance.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_op_ff   <= issue.op;
         p_data_ff <= issue.data;
         p_pal_ff  <= issue.pal;
      end
      if (p_valid_ff && p_advance) begin
         rsp_data_ff   <= rd;
         rsp_nmi_ff    <= view.nmi;
         rsp_vram_ff   <= view.vram;
         rsp_fine_x_ff <= view.fine_x;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_nmi_request   = rsp_nmi_ff;
   assign rsp_vram_address  = rsp_vram_ff;
   assign rsp_fine_x_scroll = rsp_fine_x_ff;

   `VRP_ASSERT_IMPLY(a_stall_blocks_req, p_valid_ff && !p_advance, !req_ready,
      "request taken while stage stalled")
   `VRP_ASSERT_NEXT(a_stage_reaches_rsp, p_valid_ff && p_advance, rsp_valid,
      "advanced request lost")
   `VRP_ASSERT_NEXT(a_clear_zeroes,
      p_valid_ff && p_advance && p_op_ff == vrp_pkg::OP_CLEAR,
      rsp_read_data == 8'h00 && rsp_fine_x_scroll == 3'd0,
      "soft reset response not cleared")
   `VRP_ASSERT_NEXT(a_status_read_drops_nmi,
      req_fire && req_mode == vrp_pkg::MODE_READ
         && req_register_index == vrp_pkg::REG_STATUS,
      !view.nmi, "status read kept vblank")

endmodule

/* rtl/vrp_sprite_mem.sv */
`timescale 1ns / 1ps

module vrp_sprite_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  vrp_pkg::spr_cmd_type cmd,
   output logic [7:0]           rd_data
);

   logic [7:0]                      mem [vrp_pkg::SPRITE_DEPTH];
   logic [vrp_pkg::SPRITE_DEPTH-1:0] valid_ff;
   logic [7:0]                      data_ff;
   logic                            hit_ff;

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.we) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.re) begin
         data_ff <= mem[cmd.rd_addr];
         hit_ff  <= valid_ff[cmd.rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : 8'h00;

endmodule

/* rtl/vrp_video_mem.sv */
`timescale 1ns / 1ps

module vrp_video_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  vrp_pkg::vid_cmd_type cmd,
   output vrp_pkg::vid_rsp_type rsp
);

   logic [7:0]                     mem [vrp_pkg::VIDEO_DEPTH];
   logic [vrp_pkg::PAL_DEPTH-1:0]  pal_valid_ff;
   logic [7:0]                     a_ff;
   logic [7:0]                     b_ff;
   logic [7:0]                     preset_ff;
   logic                           preset_sel_ff;
   logic                           wr_pal;
   logic                           rd_pal;
   logic [vrp_pkg::PAL_IDX_W-1:0]  wr_idx;
   logic [vrp_pkg::PAL_IDX_W-1:0]  rd_idx;

   localparam int PAGE_W = vrp_pkg::VADDR_W - vrp_pkg::PAL_IDX_W;

   assign wr_idx = cmd.wr_addr[vrp_pkg::PAL_IDX_W-1:0];
   assign rd_idx = cmd.rd_addr[vrp_pkg::PAL_IDX_W-1:0];
   assign wr_pal = cmd.wr_addr[vrp_pkg::VADDR_W-1 -: PAGE_W]
                   == vrp_pkg::PAL_BASE[vrp_pkg::VADDR_W-1 -: PAGE_W];
   assign rd_pal = cmd.rd_addr[vrp_pkg::VADDR_W-1 -: PAGE_W]
                   == vrp_pkg::PAL_BASE[vrp_pkg::VADDR_W-1 -: PAGE_W];

   // Palette window keeps its preset until the CPU overwrites an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (cmd.we && wr_pal) begin
         pal_valid_ff[wr_idx] <= 1'b1;
      end
   end

   // Port A reads the address itself, port B its buffer mirror below the palette.
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.re) begin
         a_ff          <= mem[cmd.rd_addr];
         b_ff          <= mem[cmd.rd_addr & vrp_pkg::BUF_MIRROR_MASK];
         preset_sel_ff <= rd_pal && !pal_valid_ff[rd_idx];
         preset_ff     <= vrp_pkg::palette_preset(rd_idx);
      end
   end

   assign rsp.a = preset_sel_ff ? preset_ff : a_ff;
   assign rsp.b = b_ff;

endmodule

/* rtl/vrp_regs.sv */
`timescale 1ns / 1ps

module vrp_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic [1:0]           req_mode,
   input  logic [2:0]           req_register_index,
   input  logic [7:0]           req_write_data,
   output vrp_pkg::issue_type   issue,
   output vrp_pkg::vid_cmd_type vid_cmd,
   output vrp_pkg::spr_cmd_type spr_cmd,
   output vrp_pkg::view_type    view
);

   localparam int AW = vrp_pkg::VADDR_W;

   logic                         ctrl_nmi_ff,   ctrl_nmi_in;
   logic                         ctrl_inc32_ff, ctrl_inc32_in;
   logic [2:0]                   status_ff,     status_in;
   logic [vrp_pkg::SADDR_W-1:0]  spr_addr_ff,   spr_addr_in;
   logic [AW-1:0]                cur_ff,        cur_in;
   logic [AW-1:0]                tmp_ff,        tmp_in;
   logic [2:0]                   fine_x_ff,     fine_x_in;
   logic                         toggle_ff,     toggle_in;

   logic [AW-1:0]                stride;
   vrp_pkg::mode_type            mode;
   vrp_pkg::reg_type             idx;
   logic [7:0]                   d;

   assign mode   = vrp_pkg::mode_type'(req_mode);
   assign idx    = vrp_pkg::reg_type'(req_register_index);
   assign d      = req_write_data;
   assign stride = ctrl_inc32_ff ? vrp_pkg::STRIDE_ROW : vrp_pkg::STRIDE_ONE;

   always_comb begin
      ctrl_nmi_in   = ctrl_nmi_ff;
      ctrl_inc32_in = ctrl_inc32_ff;
      status_in     = status_ff;
      spr_addr_in   = spr_addr_ff;
      cur_in        = cur_ff;
      tmp_in        = tmp_ff;
      fine_x_in     = fine_x_ff;
      toggle_in     = toggle_ff;
      issue         = '{op: vrp_pkg::OP_LATCH, data: 8'h00, pal: 1'b0};
      vid_cmd       = '0;
      spr_cmd       = '0;
      vid_cmd.rd_addr = cur_ff;
      vid_cmd.wr_addr = cur_ff;
      vid_cmd.wr_data = d;
      spr_cmd.rd_addr = spr_addr_ff;
      spr_cmd.wr_addr = spr_addr_ff;
      spr_cmd.wr_data = (spr_addr_ff[1:0] == vrp_pkg::SPR_ATTR_SLOT) ?
                        (d & vrp_pkg::SPR_ATTR_MASK) : d;
      if (req_fire) begin
         case (mode)
            vrp_pkg::MODE_READ: begin
               case (idx)
                  vrp_pkg::REG_STATUS: begin
                     issue.op   = vrp_pkg::OP_STATUS;
                     issue.data = {status_ff, 5'b0};
                     status_in  = {1'b0, status_ff[1:0]};
                     toggle_in  = 1'b0;
                  end
                  vrp_pkg::REG_SPRITE_DATA: begin
                     issue.op   = vrp_pkg::OP_SPRITE;
                     spr_cmd.re = 1'b1;
                  end
                  vrp_pkg::REG_DATA: begin
                     issue.op   = vrp_pkg::OP_DATA;
                     issue.pal  = cur_ff >= vrp_pkg::PAL_BASE;
                     vid_cmd.re = 1'b1;
                     cur_in     = cur_ff + stride;
                  end
                  default: begin
                     issue.op = vrp_pkg::OP_LATCH;
                  end
               endcase
            end
            vrp_pkg::MODE_WRITE: begin
               issue.op   = vrp_pkg::OP_WRITE;
               issue.data = d;
               case (idx)
                  vrp_pkg::REG_CONTROL: begin
                     ctrl_nmi_in   = d[7];
                     ctrl_inc32_in = d[2];
                     tmp_in[11:10] = d[1:0];
                  end
                  vrp_pkg::REG_SPRITE_ADDR: begin
                     spr_addr_in = d;
                  end
                  vrp_pkg::REG_SPRITE_DATA: begin
                     spr_cmd.we  = 1'b1;
                     spr_addr_in = spr_addr_ff + 1'b1;
                  end
                  vrp_pkg::REG_SCROLL: begin
                     if (!toggle_ff) begin
                        tmp_in[4:0] = d[7:3];
                        fine_x_in   = d[2:0];
                     end else begin
                        tmp_in[13:12] = d[1:0];
                        tmp_in[9:5]   = d[7:3];
                     end
                     toggle_in = !toggle_ff;
                  end
                  vrp_pkg::REG_ADDRESS: begin
                     if (!toggle_ff) begin
                        tmp_in[13:8] = d[5:0];
                     end else begin
                        tmp_in[7:0] = d;
                        cur_in      = {tmp_ff[13:8], d};
                     end
                     toggle_in = !toggle_ff;
                  end
                  vrp_pkg::REG_DATA: begin
                     vid_cmd.we = 1'b1;
                     cur_in     = cur_ff + stride;
                  end
                  default: begin
                     // Mask and status writes only load the bus latch here.
                     issue.op = vrp_pkg::OP_WRITE;
                  end
               endcase
            end
            vrp_pkg::MODE_RESET: begin
               issue.op      = vrp_pkg::OP_CLEAR;
               ctrl_nmi_in   = 1'b0;
               ctrl_inc32_in = 1'b0;
               toggle_in     = 1'b0;
               cur_in        = '0;
               tmp_in        = '0;
               fine_x_in     = '0;
            end
            vrp_pkg::MODE_STATUS: begin
               status_in = d[7:5];
            end
            default: begin
               issue.op = vrp_pkg::OP_LATCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_nmi_ff   <= 1'b0;
         ctrl_inc32_ff <= 1'b0;
         status_ff     <= 3'b101;
         spr_addr_ff   <= '0;
         cur_ff        <= '0;
         tmp_ff        <= '0;
         fine_x_ff     <= '0;
         toggle_ff     <= 1'b0;
      end else begin
         ctrl_nmi_ff   <= ctrl_nmi_in;
         ctrl_inc32_ff <= ctrl_inc32_in;
         status_ff     <= status_in;
         spr_addr_ff   <= spr_addr_in;
         cur_ff        <= cur_in;
         tmp_ff        <= tmp_in;
         fine_x_ff     <= fine_x_in;
         toggle_ff     <= toggle_in;
      end
   end

   assign view.nmi    = ctrl_nmi_ff && status_ff[2];
   assign view.vram   = cur_ff;
   assign view.fine_x = fine_x_ff;

endmodule
